>>> rtl/cmos_rtc_to_unix_time_unit_macros.svh
// Assertion macros for the checker file of this block.
`ifndef CMOS_RTC_TO_UNIX_TIME_UNIT_MACROS_SVH
`define CMOS_RTC_TO_UNIX_TIME_UNIT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CRTU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define CRTU_ASSERT(lbl, prop, msg) `CRTU_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/cmosrtc_pkg.sv
package cmosrtc_pkg;

  localparam int unsigned YearW         = 15;
  localparam int unsigned DaysW         = 24;
  localparam int unsigned SecsW         = 40;
  localparam int unsigned TodW          = 20;
  localparam int unsigned MonthsW       = 13;
  localparam int unsigned QuarterW      = YearW - 2;
  localparam int unsigned Recip25W      = 16;
  localparam int unsigned Recip25Shift  = 20;
  localparam int unsigned ProdW         = QuarterW + Recip25W;
  localparam int unsigned DivW          = ProdW - Recip25Shift;
  localparam int unsigned PipeDepth     = 6;

  localparam int unsigned EpochYear     = 1970;
  localparam int unsigned Recip25       = (2 ** Recip25Shift + 24) / 25;
  localparam int unsigned LeapsBeforeEpoch =
    (EpochYear - 1) / 4 - (EpochYear - 1) / 100 + (EpochYear - 1) / 400;

  localparam logic [7:0] PmBit          = 8'h80;
  localparam logic [7:0] HourMask       = 8'h7F;
  localparam logic [7:0] HoursPerHalf   = 8'd12;
  localparam logic [7:0] CenturyNone    = 8'h00;
  localparam logic [7:0] CenturyErased  = 8'hFF;
  localparam logic [7:0] PivotYear      = 8'd70;
  localparam logic [7:0] MonthsPerYear  = 8'd12;
  localparam int unsigned Base20        = 2000;
  localparam int unsigned Base19        = 1900;
  localparam int unsigned YearsPerCent  = 100;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned DaysPerXMonth = 30;
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned SecsPerHour   = 3600;
  localparam int unsigned SecsPerMin    = 60;

  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBinaryMode = 1'b0,
    CfgHour24Mode = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
  } fields_t;

  typedef struct packed {
    logic       valid;
    fields_t    f;
    logic [7:0] yy;
    logic [7:0] cen;
  } dec_beat_t;

  typedef struct packed {
    logic             valid;
    fields_t          f;
    logic [YearW-1:0] year;
    logic [DaysW-1:0] days;
  } days_beat_t;

  typedef struct packed {
    logic             valid;
    fields_t          f;
    logic [YearW-1:0] year;
    logic [SecsW-1:0] epoch;
  } res_beat_t;

  function automatic logic [7:0] decode_byte(input logic [7:0] raw, input logic bin);
    logic [7:0] bcd;
    bcd = 8'(raw[7:4]) * 8'd10 + 8'(raw[3:0]);
    return bin ? raw : bcd;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/cmos_rtc_to_unix_time_unit.sv
// Channel     | Ports                                   | Beat taken when
// ------------+-----------------------------------------+------------------------
// snapshot in | start_i, busy_o, raw_*_i                | start_i && !busy_o
// config      | cfg_we_i, cfg_idx_i, cfg_wdata_i        | cfg_we_i
// result out  | done_o, full_year_o .. epoch_seconds_o  | done_o (one cycle)
//
// A snapshot may start in every cycle; busy_o is always low.
// Each result passes through six register stages after its start:
// decode, year assembly, reciprocal products, day total, scaling and final add.
// Reset clears the stage valid bits and sets 24-hour BCD mode.
// The result side cannot stall, so the pipeline never holds.
module cmos_rtc_to_unix_time_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 cfg_we_i,
  input  logic [cmosrtc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cmosrtc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [7:0]                           raw_seconds_i,
  input  logic [7:0]                           raw_minutes_i,
  input  logic [7:0]                           raw_hours_i,
  input  logic [7:0]                           raw_day_i,
  input  logic [7:0]                           raw_month_i,
  input  logic [7:0]                           raw_year_i,
  input  logic [7:0]                           raw_century_i,
  output logic                                 done_o,
  output logic [cmosrtc_pkg::YearW-1:0]        full_year_o,
  output logic [7:0]                           month_out_o,
  output logic [7:0]                           day_out_o,
  output logic [7:0]                           hour_out_o,
  output logic [7:0]                           minute_out_o,
  output logic [7:0]                           second_out_o,
  output logic [cmosrtc_pkg::SecsW-1:0]        epoch_seconds_o
);

  logic                    binary_mode_q, hour24_mode_q;
  cmosrtc_pkg::dec_beat_t  dec_beat;
  cmosrtc_pkg::days_beat_t days_beat;
  cmosrtc_pkg::res_beat_t  res_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= 1'b0;
      hour24_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cmosrtc_pkg::cfg_idx_e'(cfg_idx_i))
        cmosrtc_pkg::CfgBinaryMode: binary_mode_q <= cfg_wdata_i[0];
        cmosrtc_pkg::CfgHour24Mode: hour24_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cmosrtc_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .binary_mode_i (binary_mode_q),
    .hour24_mode_i (hour24_mode_q),
    .raw_seconds_i (raw_seconds_i),
    .raw_minutes_i (raw_minutes_i),
    .raw_hours_i   (raw_hours_i),
    .raw_day_i     (raw_day_i),
    .raw_month_i   (raw_month_i),
    .raw_year_i    (raw_year_i),
    .raw_century_i (raw_century_i),
    .beat_o        (dec_beat)
  );

  cmosrtc_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (dec_beat),
    .beat_o (days_beat)
  );

  cmosrtc_secs u_secs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (days_beat),
    .beat_o (res_beat)
  );

  assign busy_o          = 1'b0;
  assign done_o          = res_beat.valid;
  assign full_year_o     = res_beat.year;
  assign month_out_o     = res_beat.f.month;
  assign day_out_o       = res_beat.f.day;
  assign hour_out_o      = res_beat.f.hour;
  assign minute_out_o    = res_beat.f.minute;
  assign second_out_o    = res_beat.f.second;
  assign epoch_seconds_o = res_beat.epoch;

endmodule

>>> rtl/cmosrtc_decode.sv
module cmosrtc_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   binary_mode_i,
  input  logic                   hour24_mode_i,
  input  logic [7:0]             raw_seconds_i,
  input  logic [7:0]             raw_minutes_i,
  input  logic [7:0]             raw_hours_i,
  input  logic [7:0]             raw_day_i,
  input  logic [7:0]             raw_month_i,
  input  logic [7:0]             raw_year_i,
  input  logic [7:0]             raw_century_i,
  output cmosrtc_pkg::dec_beat_t beat_o
);

  logic                    valid_q;
  cmosrtc_pkg::fields_t    f_d, f_q;
  logic [7:0]              yy_d, yy_q, cen_d, cen_q;
  logic                    pm;
  logic [7:0]              hraw, hdec;

  always_comb begin
    pm   = !hour24_mode_i && ((raw_hours_i & cmosrtc_pkg::PmBit) != 8'd0);
    hraw = pm ? (raw_hours_i & cmosrtc_pkg::HourMask) : raw_hours_i;
    hdec = cmosrtc_pkg::decode_byte(hraw, binary_mode_i);
    f_d.second = cmosrtc_pkg::decode_byte(raw_seconds_i, binary_mode_i);
    f_d.minute = cmosrtc_pkg::decode_byte(raw_minutes_i, binary_mode_i);
    f_d.day    = cmosrtc_pkg::decode_byte(raw_day_i, binary_mode_i);
    f_d.month  = cmosrtc_pkg::decode_byte(raw_month_i, binary_mode_i);
    f_d.hour   = hdec;
    if (!hour24_mode_i) begin
      if (pm && hdec < cmosrtc_pkg::HoursPerHalf) begin
        f_d.hour = hdec + cmosrtc_pkg::HoursPerHalf;
      end else if (!pm && hdec == cmosrtc_pkg::HoursPerHalf) begin
        f_d.hour = 8'd0;
      end
    end
    yy_d  = cmosrtc_pkg::decode_byte(raw_year_i, binary_mode_i);
    cen_d = cmosrtc_pkg::decode_byte(raw_century_i, binary_mode_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      f_q   <= f_d;
      yy_q  <= yy_d;
      cen_q <= cen_d;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.f     = f_q;
  assign beat_o.yy    = yy_q;
  assign beat_o.cen   = cen_q;

endmodule

>>> rtl/cmosrtc_days.sv
module cmosrtc_days (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmosrtc_pkg::dec_beat_t  beat_i,
  output cmosrtc_pkg::days_beat_t beat_o
);

  localparam int unsigned YearW    = cmosrtc_pkg::YearW;
  localparam int unsigned DaysW    = cmosrtc_pkg::DaysW;
  localparam int unsigned QuarterW = cmosrtc_pkg::QuarterW;
  localparam int unsigned ProdW    = cmosrtc_pkg::ProdW;
  localparam int unsigned DivW     = cmosrtc_pkg::DivW;
  localparam int unsigned MonthsW  = cmosrtc_pkg::MonthsW;
  localparam int unsigned Shift    = cmosrtc_pkg::Recip25Shift;

  // Year assembly, epoch clamp, month index and day offset.
  logic                 s2_valid_q;
  cmosrtc_pkg::fields_t s2_f_q;
  logic [YearW-1:0]     s2_year_d, s2_year_q, s2_ey_d, s2_ey_q;
  logic [7:0]           s2_months_d, s2_months_q, s2_dayoff_d, s2_dayoff_q;

  always_comb begin
    if (beat_i.cen == cmosrtc_pkg::CenturyNone || beat_i.cen == cmosrtc_pkg::CenturyErased) begin
      s2_year_d = (beat_i.yy < cmosrtc_pkg::PivotYear ? YearW'(cmosrtc_pkg::Base20)
                                                      : YearW'(cmosrtc_pkg::Base19))
                  + YearW'(beat_i.yy);
    end else begin
      s2_year_d = YearW'(beat_i.cen) * YearW'(cmosrtc_pkg::YearsPerCent) + YearW'(beat_i.yy);
    end
    s2_ey_d = (s2_year_d < YearW'(cmosrtc_pkg::EpochYear)) ? YearW'(cmosrtc_pkg::EpochYear)
                                                           : s2_year_d;
    s2_months_d = (beat_i.f.month >= 8'd1) ? beat_i.f.month - 8'd1 : 8'd0;
    s2_dayoff_d = (beat_i.f.day >= 8'd1) ? beat_i.f.day - 8'd1 : 8'd0;
  end

  // Reciprocal products for the divisions by 25, year days and month days.
  logic                 s3_valid_q;
  cmosrtc_pkg::fields_t s3_f_q;
  logic [YearW-1:0]     s3_year_q, ey_m1;
  logic [DaysW-1:0]     s3_yd_d, s3_yd_q;
  logic [QuarterW-1:0]  s3_qn_q, s3_qe_q;
  logic [ProdW-1:0]     s3_pn_d, s3_pn_q, s3_pe_d, s3_pe_q;
  logic [1:0]           s3_eylo_q;
  logic [MonthsW-1:0]   s3_mdays_d, s3_mdays_q;
  logic                 s3_leapok_q;
  logic [7:0]           s3_dayoff_q;

  always_comb begin
    ey_m1   = s2_ey_q - YearW'(1);
    s3_yd_d = DaysW'(s2_ey_q - YearW'(cmosrtc_pkg::EpochYear))
              * DaysW'(cmosrtc_pkg::DaysPerYear);
    s3_pn_d = ProdW'(ey_m1[YearW-1:2]) * ProdW'(cmosrtc_pkg::Recip25);
    s3_pe_d = ProdW'(s2_ey_q[YearW-1:2]) * ProdW'(cmosrtc_pkg::Recip25);
    if (s2_months_q > cmosrtc_pkg::MonthsPerYear) begin
      s3_mdays_d = MonthsW'(cmosrtc_pkg::DaysPerYear)
                   + MonthsW'(s2_months_q - cmosrtc_pkg::MonthsPerYear)
                   * MonthsW'(cmosrtc_pkg::DaysPerXMonth);
    end else begin
      s3_mdays_d = MonthsW'(cmosrtc_pkg::days_before_month(s2_months_q[3:0]));
    end
  end

  // Leap-year counts and the day total.
  logic                 s4_valid_q;
  cmosrtc_pkg::fields_t s4_f_q;
  logic [YearW-1:0]     s4_year_q;
  logic [DaysW-1:0]     s4_days_d, s4_days_q;
  logic [DivW-1:0]      an, ae;
  logic [QuarterW-1:0]  ln;
  logic                 div4, div100, leap;

  always_comb begin
    an     = s3_pn_q[ProdW-1:Shift];
    ae     = s3_pe_q[ProdW-1:Shift];
    ln     = s3_qn_q - QuarterW'(an) + QuarterW'(an[DivW-1:2]);
    div4   = (s3_eylo_q == 2'd0);
    div100 = div4 && ((QuarterW + 1)'(ae) * (QuarterW + 1)'(25) == (QuarterW + 1)'(s3_qe_q));
    leap   = (div4 && !div100) || (div100 && ae[1:0] == 2'd0);
    s4_days_d = s3_yd_q + DaysW'(ln) - DaysW'(cmosrtc_pkg::LeapsBeforeEpoch)
                + DaysW'(s3_mdays_q) + DaysW'(leap && s3_leapok_q) + DaysW'(s3_dayoff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= beat_i.valid;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_f_q      <= beat_i.f;
    s2_year_q   <= s2_year_d;
    s2_ey_q     <= s2_ey_d;
    s2_months_q <= s2_months_d;
    s2_dayoff_q <= s2_dayoff_d;

    s3_f_q      <= s2_f_q;
    s3_year_q   <= s2_year_q;
    s3_yd_q     <= s3_yd_d;
    s3_qn_q     <= ey_m1[YearW-1:2];
    s3_qe_q     <= s2_ey_q[YearW-1:2];
    s3_pn_q     <= s3_pn_d;
    s3_pe_q     <= s3_pe_d;
    s3_eylo_q   <= s2_ey_q[1:0];
    s3_mdays_q  <= s3_mdays_d;
    s3_leapok_q <= (s2_months_q >= 8'd2);
    s3_dayoff_q <= s2_dayoff_q;

    s4_f_q      <= s3_f_q;
    s4_year_q   <= s3_year_q;
    s4_days_q   <= s4_days_d;
  end

  assign beat_o.valid = s4_valid_q;
  assign beat_o.f     = s4_f_q;
  assign beat_o.year  = s4_year_q;
  assign beat_o.days  = s4_days_q;

endmodule

>>> rtl/cmosrtc_secs.sv
module cmosrtc_secs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmosrtc_pkg::days_beat_t beat_i,
  output cmosrtc_pkg::res_beat_t  beat_o
);

  localparam int unsigned YearW = cmosrtc_pkg::YearW;
  localparam int unsigned SecsW = cmosrtc_pkg::SecsW;
  localparam int unsigned TodW  = cmosrtc_pkg::TodW;

  logic                 s5_valid_q, s6_valid_q;
  cmosrtc_pkg::fields_t s5_f_q, s6_f_q;
  logic [YearW-1:0]     s5_year_q, s6_year_q;
  logic [SecsW-1:0]     s5_dsec_d, s5_dsec_q, s6_epoch_d, s6_epoch_q;
  logic [TodW-1:0]      s5_tod_d, s5_tod_q;

  always_comb begin
    s5_dsec_d  = SecsW'(beat_i.days) * SecsW'(cmosrtc_pkg::SecsPerDay);
    s5_tod_d   = TodW'(beat_i.f.hour) * TodW'(cmosrtc_pkg::SecsPerHour)
                 + TodW'(beat_i.f.minute) * TodW'(cmosrtc_pkg::SecsPerMin)
                 + TodW'(beat_i.f.second);
    s6_epoch_d = s5_dsec_q + SecsW'(s5_tod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= beat_i.valid;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_f_q     <= beat_i.f;
    s5_year_q  <= beat_i.year;
    s5_dsec_q  <= s5_dsec_d;
    s5_tod_q   <= s5_tod_d;
    s6_f_q     <= s5_f_q;
    s6_year_q  <= s5_year_q;
    s6_epoch_q <= s6_epoch_d;
  end

  assign beat_o.valid = s6_valid_q;
  assign beat_o.f     = s6_f_q;
  assign beat_o.year  = s6_year_q;
  assign beat_o.epoch = s6_epoch_q;

endmodule

>>> rtl/cmosrtc_checker.sv
`include "cmos_rtc_to_unix_time_unit_macros.svh"

module cmosrtc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [cmosrtc_pkg::YearW-1:0]  full_year_o,
  input logic [7:0]                     month_out_o,
  input logic [7:0]                     day_out_o,
  input logic [7:0]                     hour_out_o,
  input logic [7:0]                     minute_out_o,
  input logic [7:0]                     second_out_o,
  input logic [cmosrtc_pkg::SecsW-1:0]  epoch_seconds_o
);

  localparam int unsigned SecsW = cmosrtc_pkg::SecsW;

  logic [SecsW-1:0] tod;

  assign tod = SecsW'(hour_out_o) * SecsW'(cmosrtc_pkg::SecsPerHour)
               + SecsW'(minute_out_o) * SecsW'(cmosrtc_pkg::SecsPerMin)
               + SecsW'(second_out_o);

  `CRTU_ASSERT(a_beat_latency, (start_i && !busy_o) |-> ##(cmosrtc_pkg::PipeDepth) done_o, "Accepted snapshot gave no result at the pipeline depth.")

  `CRTU_ASSERT(a_no_spurious, !(start_i && !busy_o) |-> ##(cmosrtc_pkg::PipeDepth) !done_o, "Result appeared without an accepted snapshot.")

  `CRTU_ASSERT(a_tod_floor, done_o |-> (epoch_seconds_o >= tod), "Epoch count is below the time of day.")

  `CRTU_ASSERT(a_epoch_origin, (done_o && full_year_o <= 15'd1970 && month_out_o <= 8'd1 && day_out_o <= 8'd1) |-> (epoch_seconds_o == tod), "First epoch day does not count from zero.")

endmodule

bind cmos_rtc_to_unix_time_unit cmosrtc_checker u_cmosrtc_checker (.*);
